>>> rtl/rsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types, codes and the pixel shading function of the sprite blitter.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int FB_DEPTH_DEFAULT = 131072;
  localparam int PTR_W            = 20;
  localparam int LIMIT_W          = 19;

  localparam logic [9:0] PITCH_RESET = 10'd320;
  localparam logic [8:0] ROWS_RESET  = 9'd200;

  localparam logic CFG_ROW_PITCH    = 1'b0;
  localparam logic CFG_SURFACE_ROWS = 1'b1;

  localparam logic [7:0] CODE_SKIP_RUN = 8'd255;
  localparam logic [7:0] CODE_ROW_END  = 8'd254;
  localparam logic [7:0] CODE_SKIP_ONE = 8'd253;

  localparam logic [7:0] SAT_LOW  = 8'h0f;
  localparam logic [7:0] SAT_HIGH = 8'h1f;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CODE  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MODE_COPY      = 3'd0,
    MODE_BLEND     = 3'd1,
    MODE_HV_UNSAFE = 3'd2,
    MODE_HV        = 3'd3,
    MODE_HV_BLEND  = 3'd4,
    MODE_HALVE     = 3'd5,
    MODE_BLACK     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_HWRITE = 2'd2,
    KIND_HREAD  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [PTR_W-1:0]   addr;
    logic [7:0]         code;
    logic [2:0]         mode;
    logic [3:0]         hue;
    logic [7:0]         value;
    logic [7:0]         data;
    logic               active;
    logic               aborted;
    logic               written;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       active;
    logic       aborted;
    logic       written;
  } result_t;

  function automatic logic [7:0] shade(logic [2:0] mode, logic [3:0] hue,
                                       logic [7:0] value, logic [7:0] code,
                                       logic [7:0] old);
    logic [7:0] s;
    logic [7:0] t;
    logic [4:0] sum_c;
    logic [4:0] sum_t;
    logic [7:0] pix;
    s = {4'b0, code[3:0]} + value;
    t = s;
    if (s > SAT_LOW) begin
      t = (s >= SAT_HIGH) ? 8'h00 : SAT_LOW;
    end
    sum_c = {1'b0, old[3:0]} + {1'b0, code[3:0]};
    sum_t = {1'b0, old[3:0]} + t[4:0];
    case (mode_t'(mode))
      MODE_BLEND:     pix = {code[7:4], sum_c[4:1]};
      MODE_HV_UNSAFE: pix = {hue, 4'b0} | s;
      MODE_HV:        pix = {hue, t[3:0]};
      MODE_HV_BLEND:  pix = {hue, sum_t[4:1]};
      MODE_HALVE:     pix = {old[7:4], 1'b0, old[3:1]};
      MODE_BLACK:     pix = 8'h00;
      default:        pix = code;
    endcase
    return pix;
  endfunction

endpackage

>>> rtl/rle_sprite_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_blitter
// Run-length sprite decoder drawing into an 8-bit frame store, with host
// pixel write and read beats.
// ----------------------------------------------------------------------------
// Every input beat gives one result beat, via the shading stage register and
// the result queue. A new beat is taken every cycle unless input stalls: each
// beat reads the frame store, is shaded in the next cycle and written back
// there while the following beat reads, and a one-entry forward serves a read
// of the address just written. A four-entry result queue lets input continue
// while results wait; input stalls when the queue and the shading stage
// together hold four beats. The frame store has no reset and no clearing pass.
module rle_sprite_blitter #(
  parameter int FB_DEPTH = rsb_pkg::FB_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        func,
  input  logic signed [9:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [9:0]        sprite_width,
  input  logic [9:0]        sprite_height,
  input  logic [2:0]        draw_mode,
  input  logic [3:0]        hue,
  input  logic signed [7:0] value_shift,
  input  logic [7:0]        code_byte,
  input  logic [16:0]       pixel_address,
  input  logic [7:0]        pixel_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data,
  output logic              blit_active,
  output logic              blit_aborted,
  output logic              pixel_written
);
  import rsb_pkg::*;

  localparam int Q_DEPTH = 4;

  logic     accept;
  mem_req_t req;
  logic     s1_valid;
  result_t  res;
  result_t  head;
  logic [2:0] q_count;
  logic     pop;

  assign in_stall = (32'(q_count) + 32'(s1_valid)) >= Q_DEPTH;
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  rsb_ctrl #(.FB_DEPTH(FB_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .func          (func),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .sprite_width  (sprite_width),
    .sprite_height (sprite_height),
    .draw_mode     (draw_mode),
    .hue           (hue),
    .value_shift   (value_shift),
    .code_byte     (code_byte),
    .pixel_address (pixel_address),
    .pixel_data    (pixel_data),
    .req           (req)
  );

  rsb_pixel #(.FB_DEPTH(FB_DEPTH)) u_pixel (
    .clk       (clk),
    .rst       (rst),
    .req_valid (accept),
    .req       (req),
    .s1_valid  (s1_valid),
    .res       (res)
  );

  rsb_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .count     (q_count),
    .head_data (head)
  );

  assign read_data     = head.read_data;
  assign blit_active   = head.active;
  assign blit_aborted  = head.aborted;
  assign pixel_written = head.written;

endmodule

>>> rtl/rsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_ctrl
// Configuration registers, blit state and code byte decoder. Issues one
// frame store request per accepted beat.
// ----------------------------------------------------------------------------
module rsb_ctrl #(
  parameter int FB_DEPTH = rsb_pkg::FB_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic              accept,
  input  logic [1:0]        func,
  input  logic signed [9:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [9:0]        sprite_width,
  input  logic [9:0]        sprite_height,
  input  logic [2:0]        draw_mode,
  input  logic [3:0]        hue,
  input  logic signed [7:0] value_shift,
  input  logic [7:0]        code_byte,
  input  logic [16:0]       pixel_address,
  input  logic [7:0]        pixel_data,
  output rsb_pkg::mem_req_t req
);
  import rsb_pkg::*;

  localparam int RESET_PROD = 64000;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT =
    LIMIT_W'((RESET_PROD < FB_DEPTH) ? RESET_PROD : FB_DEPTH);

  logic [9:0]         row_pitch;
  logic [8:0]         surface_rows;
  logic [LIMIT_W-1:0] limit;
  logic [PTR_W-1:0]   ptr;
  logic [10:0]        col;
  logic [9:0]         row;
  logic               expect_count;
  logic               active;
  logic [9:0]         lat_width;
  logic [9:0]         lat_height;
  logic [2:0]         lat_mode;
  logic [3:0]         lat_hue;
  logic [7:0]         lat_value;

  logic [PTR_W-1:0]   ptr_next;
  logic [10:0]        col_next;
  logic [9:0]         row_next;
  logic               expect_count_next;
  logic               active_next;

  logic [8:0]         mul_rows;
  logic [9:0]         mul_pitch;
  logic [LIMIT_W-1:0] prod;
  logic [LIMIT_W-1:0] limit_next;
  logic signed [PTR_W-1:0] start_prod;
  logic [PTR_W-1:0]   start_ptr;

  always_comb begin
    mul_rows  = (cfg_index == CFG_SURFACE_ROWS) ? cfg_data[8:0] : surface_rows;
    mul_pitch = (cfg_index == CFG_ROW_PITCH) ? cfg_data : row_pitch;
    prod      = mul_rows * mul_pitch;
    limit_next = (32'(prod) < FB_DEPTH) ? prod : LIMIT_W'(FB_DEPTH);
  end

  assign start_prod = $signed(pos_y) * $signed({1'b0, row_pitch});
  assign start_ptr  = start_prod + PTR_W'(pos_x);

  always_comb begin
    logic             do_adv;
    logic             do_check;
    logic             forced;
    logic [7:0]       step;
    logic [PTR_W-1:0] ptr_a;
    logic [10:0]      col_a;
    logic             neg;
    do_adv   = 1'b0;
    do_check = 1'b0;
    forced   = 1'b0;
    step     = 8'd1;
    neg      = ptr[PTR_W-1];

    ptr_next          = ptr;
    col_next          = col;
    row_next          = row;
    expect_count_next = expect_count;
    active_next       = active;

    req         = '0;
    req.kind    = KIND_NONE;
    req.code    = code_byte;
    req.mode    = lat_mode;
    req.hue     = lat_hue;
    req.value   = lat_value;
    req.data    = pixel_data;

    case (func_t'(func))
      FUNC_START: begin
        ptr_next          = start_ptr;
        col_next          = '0;
        row_next          = '0;
        expect_count_next = 1'b0;
        active_next       = (sprite_height != 10'd0);
        req.mode          = draw_mode;
        req.hue           = hue;
        req.value         = value_shift;
      end
      FUNC_CODE: begin
        if (active) begin
          if (expect_count) begin
            expect_count_next = 1'b0;
            do_adv   = 1'b1;
            step     = code_byte;
            do_check = 1'b1;
            forced   = (code_byte == CODE_ROW_END);
          end else if (code_byte == CODE_SKIP_RUN) begin
            expect_count_next = 1'b1;
          end else if (code_byte == CODE_ROW_END) begin
            do_check = 1'b1;
            forced   = 1'b1;
          end else if (code_byte == CODE_SKIP_ONE) begin
            do_adv   = 1'b1;
            do_check = 1'b1;
          end else if (!neg && (ptr[LIMIT_W-1:0] >= limit)) begin
            active_next = 1'b0;
            req.aborted = 1'b1;
          end else begin
            if (!neg) begin
              req.kind    = KIND_DRAW;
              req.addr    = ptr;
              req.written = 1'b1;
            end
            do_adv   = 1'b1;
            do_check = 1'b1;
          end
        end
      end
      FUNC_WRITE, FUNC_READ: begin
        if ({4'b0, pixel_address} < 21'(FB_DEPTH)) begin
          req.kind = (func_t'(func) == FUNC_WRITE) ? KIND_HWRITE : KIND_HREAD;
        end
        req.addr = PTR_W'(pixel_address);
      end
      default: begin
      end
    endcase

    ptr_a = ptr + (do_adv ? PTR_W'(step) : '0);
    col_a = col + (do_adv ? 11'(step) : 11'd0);
    if (do_adv || do_check) begin
      ptr_next = ptr_a;
      col_next = col_a;
    end
    if (do_check && (forced || col_a >= {1'b0, lat_width})) begin
      ptr_next = ptr_a + PTR_W'(row_pitch) - PTR_W'(col_a);
      col_next = '0;
      row_next = row + 10'd1;
      if (row_next >= lat_height) begin
        active_next = 1'b0;
      end
    end

    req.active = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch    <= PITCH_RESET;
      surface_rows <= ROWS_RESET;
      limit        <= RESET_LIMIT;
    end else if (cfg_we) begin
      limit <= limit_next;
      if (cfg_index == CFG_ROW_PITCH) begin
        row_pitch <= cfg_data;
      end else begin
        surface_rows <= cfg_data[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr          <= '0;
      col          <= '0;
      row          <= '0;
      expect_count <= 1'b0;
      active       <= 1'b0;
      lat_width    <= '0;
      lat_height   <= '0;
      lat_mode     <= '0;
      lat_hue      <= '0;
      lat_value    <= '0;
    end else if (accept) begin
      ptr          <= ptr_next;
      col          <= col_next;
      row          <= row_next;
      expect_count <= expect_count_next;
      active       <= active_next;
      if (func_t'(func) == FUNC_START) begin
        lat_width  <= sprite_width;
        lat_height <= sprite_height;
        lat_mode   <= draw_mode;
        lat_hue    <= hue;
        lat_value  <= value_shift;
      end
    end
  end

endmodule

>>> rtl/rsb_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_pixel
// Frame store with registered read, shading stage and write-back. A one-entry
// forward covers a read issued in the cycle of a write to the same address.
// ----------------------------------------------------------------------------
module rsb_pixel #(
  parameter int FB_DEPTH = rsb_pkg::FB_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  rsb_pkg::mem_req_t req,
  output logic              s1_valid,
  output rsb_pkg::result_t  res
);
  import rsb_pkg::*;

  localparam int AW = $clog2(FB_DEPTH);

  logic [7:0]    mem [FB_DEPTH];
  logic [7:0]    rdata;
  mem_req_t      s1;
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [7:0]    fwd_data;

  logic [AW-1:0] s1_addr;
  logic [7:0]    old;
  logic [7:0]    wdata;
  logic          we;

  assign s1_addr = s1.addr[AW-1:0];
  assign old     = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
  assign wdata   = (s1.kind == KIND_HWRITE) ? s1.data
                 : shade(s1.mode, s1.hue, s1.value, s1.code, old);
  assign we      = s1_valid && (s1.kind == KIND_DRAW || s1.kind == KIND_HWRITE);

  always_ff @(posedge clk) begin
    rdata <= mem[req.addr[AW-1:0]];
    if (we) begin
      mem[s1_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= req_valid;
      fwd_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    s1       <= req;
    fwd_addr <= s1_addr;
    fwd_data <= wdata;
  end

  always_comb begin
    res.read_data = (s1.kind == KIND_HREAD) ? old : 8'h00;
    res.active    = s1.active;
    res.aborted   = s1.aborted;
    res.written   = s1.written;
  end

endmodule

>>> rtl/rsb_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_outq
// Four-entry result queue between the shading stage and the output channel.
// ----------------------------------------------------------------------------
module rsb_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rsb_pkg::result_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output logic [2:0]       count,
  output rsb_pkg::result_t head_data
);
  import rsb_pkg::*;

  result_t    q [4];
  logic [1:0] head;
  logic [1:0] tail;

  assign not_empty = (count != 3'd0);
  assign head_data = q[head];

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 2'd1;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

>>> rtl/rsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsb_checker
// Port-level checks on the result channel of the sprite blitter.
// ----------------------------------------------------------------------------
module rsb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       blit_active,
  input logic       blit_aborted,
  input logic       pixel_written
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_abort_ends_blit: assert property (@(posedge clk) disable iff (rst)
    out_valid && blit_aborted |-> !blit_active)
    else $error("aborted beat reports an active blit");

  a_abort_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(blit_aborted && pixel_written))
    else $error("aborted beat reports a written pixel");

  a_read_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 8'h00) |-> !pixel_written && !blit_aborted)
    else $error("read data on a code byte beat");

endmodule

bind rle_sprite_blitter rsb_checker u_rsb_checker (.*);
